### rtl/itrd_pkg.sv
// Shared types, constants and helper functions for the radix digit converter.
// No dependencies; every other file except itrd_ram refers to this package by scoped names.
`timescale 1ns / 1ps

package itrd_pkg;

    // Sizing
    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 64;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    // Field widths fixed by the interface
    localparam int RADIX_W = 6;
    localparam int PAD_W   = 7;
    localparam int CHAR_W  = 8;

    // Character and radix constants
    localparam logic [RADIX_W-1:0] DEC_LIMIT = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;

    // One queued conversion job, already clamped and masked
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
        logic [CNT_W-1:0]      pad;
    } t_job;

    // Digit value 0..35 to ASCII '0'..'9', 'A'..'Z'
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W - RADIX_W){1'b0}}, d};
        if (d < DEC_LIMIT) begin
            return dx + CHAR_ZERO;
        end
        return dx - {{(CHAR_W - RADIX_W){1'b0}}, DEC_LIMIT} + CHAR_A;
    endfunction

endpackage

### rtl/itrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/itrd_front.sv
// Front end: takes input transactions, clamps radix and pad width, masks the value.
// Depends on itrd_pkg.
`timescale 1ns / 1ps

module itrd_front (
    input  logic                                i_valid,
    input  logic [63:0]                         i_value,
    input  logic [itrd_pkg::RADIX_W-1:0]        i_radix,
    input  logic [itrd_pkg::PAD_W-1:0]          i_pad_width,
    input  logic                                i_full,
    output logic                                o_stall,
    output logic                                o_push,
    output itrd_pkg::t_job                      o_job
);

    logic [itrd_pkg::RADIX_W-1:0] w_radix;
    logic [itrd_pkg::CNT_W-1:0]   w_pad;

    // Radix limited to 2..36
    always_comb begin
        if (i_radix < itrd_pkg::RADIX_MIN) begin
            w_radix = itrd_pkg::RADIX_MIN;
        end else if (i_radix > itrd_pkg::RADIX_MAX) begin
            w_radix = itrd_pkg::RADIX_MAX;
        end else begin
            w_radix = i_radix;
        end
    end

    // Pad width limited to the digit store depth
    always_comb begin
        if (i_pad_width > itrd_pkg::PAD_W'(itrd_pkg::MAX_DIGITS)) begin
            w_pad = itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS);
        end else begin
            w_pad = itrd_pkg::CNT_W'(i_pad_width);
        end
    end

    assign o_stall     = i_full;
    assign o_push      = i_valid && !i_full;
    assign o_job.value = i_value[itrd_pkg::VALUE_BITS-1:0];
    assign o_job.radix = w_radix;
    assign o_job.pad   = w_pad;

endmodule

### rtl/itrd_queue.sv
// Short job queue between the front end and the conversion engine.
// Depends on itrd_pkg.
`timescale 1ns / 1ps

module itrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itrd_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output itrd_pkg::t_job o_job
);

    itrd_pkg::t_job                r_slot [itrd_pkg::QDEPTH];
    logic [itrd_pkg::QPTR_W-1:0]   r_wptr;
    logic [itrd_pkg::QPTR_W-1:0]   r_rptr;
    logic [itrd_pkg::QPTR_W:0]     r_count;
    logic                          w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_full  = (r_count == (itrd_pkg::QPTR_W + 1)'(itrd_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rptr];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

### rtl/itrd_back.sv
// Conversion engine: bit-serial division by the radix, digit stack, character output.
// Depends on itrd_pkg and itrd_ram.
`timescale 1ns / 1ps

module itrd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  itrd_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [itrd_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                          o_last
);

    localparam int VB = itrd_pkg::VALUE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state                          r_state;
    logic [VB-1:0]                   r_quot;
    logic [itrd_pkg::RADIX_W-1:0]    r_rem;
    logic [itrd_pkg::BIT_W-1:0]      r_bit;
    logic [itrd_pkg::RADIX_W-1:0]    r_radix;
    logic [itrd_pkg::CNT_W-1:0]      r_pad;
    logic [itrd_pkg::CNT_W-1:0]      r_count;
    logic [itrd_pkg::CNT_W-1:0]      r_fe;
    logic                            r_out_valid;
    logic [itrd_pkg::CHAR_W-1:0]     r_out_char;
    logic                            r_out_last;

    logic [itrd_pkg::RADIX_W:0]      w_trial;
    logic                            w_ge;
    logic [itrd_pkg::RADIX_W:0]      w_diff;
    logic [itrd_pkg::RADIX_W-1:0]    n_rem;
    logic [VB-1:0]                   n_quot;
    logic [itrd_pkg::CNT_W-1:0]      n_count;
    logic [itrd_pkg::CNT_W-1:0]      n_total;
    logic                            w_div_last;
    logic                            w_wr;
    logic                            w_rd;
    logic                            w_out_free;
    logic [itrd_pkg::RADIX_W-1:0]    w_rd_digit;
    logic [itrd_pkg::CHAR_W-1:0]     n_char;

    // One restoring division step per cycle
    assign w_trial    = {r_rem, r_quot[VB-1]};
    assign w_ge       = (w_trial >= {1'b0, r_radix});
    assign w_diff     = w_trial - {1'b0, r_radix};
    assign n_rem      = w_ge ? w_diff[itrd_pkg::RADIX_W-1:0] : w_trial[itrd_pkg::RADIX_W-1:0];
    assign n_quot     = {r_quot[VB-2:0], w_ge};
    assign w_div_last = (r_bit == itrd_pkg::BIT_W'(VB - 1));
    assign n_count    = r_count + 1'b1;
    assign n_total    = (n_count > r_pad) ? n_count : r_pad;

    // Digit stack
    assign w_wr = (r_state == S_DIV) && w_div_last;
    assign w_rd = (r_state == S_EMIT_RD);

    itrd_ram #(
        .WIDTH (itrd_pkg::RADIX_W),
        .DEPTH (itrd_pkg::MAX_DIGITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_count[itrd_pkg::IDX_W-1:0]),
        .i_wdata (n_rem),
        .i_re    (w_rd),
        .i_raddr (r_fe[itrd_pkg::IDX_W-1:0]),
        .o_rdata (w_rd_digit)
    );

    // Positions beyond the collected digits are leading zeros
    assign n_char = (r_fe < r_count) ? itrd_pkg::digit_to_char(w_rd_digit)
                                     : itrd_pkg::CHAR_ZERO;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && i_job_valid;

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_quot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register refills from the emit state, else empties on acceptance
            if ((r_state == S_EMIT_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_quot  <= i_job.value;
                        r_radix <= i_job.radix;
                        r_pad   <= i_job.pad;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_count <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quot <= n_quot;
                    if (w_div_last) begin
                        r_count <= n_count;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        if ((n_quot == '0) ||
                            (n_count >= itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS))) begin
                            r_fe    <= n_total - 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (w_out_free) begin
                        r_out_char  <= n_char;
                        r_out_last  <= (r_fe == '0);
                        if (r_fe == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_fe    <= r_fe - 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;

endmodule

### rtl/integer_to_radix_digits_top.sv
// Converts an unsigned 64-bit value to ASCII digits in base 2..36, most significant
// first, with leading '0' fill up to pad_width and a last flag on the final character.
// Input transactions enter a two-deep job queue, so up to two further numbers can be
// taken while one is converted. Each number is taken from the queue, then each collected
// digit (at least one, up to 64) needs a full pass of the bit-serial divider over
// VALUE_BITS bits, and each emitted character goes through a digit stack read and then
// the output register. Radix below 2 is taken as 2, above 36 as 36, and pad width above
// 64 as 64. Depends on itrd_pkg, itrd_front, itrd_queue and itrd_back.
`timescale 1ns / 1ps

module integer_to_radix_digits_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [63:0]                        i_value,
    input  logic [itrd_pkg::RADIX_W-1:0]       i_radix,
    input  logic [itrd_pkg::PAD_W-1:0]         i_pad_width,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [itrd_pkg::CHAR_W-1:0]        o_digit_char,
    output logic                               o_last
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_job_valid;
    itrd_pkg::t_job w_in_job;
    itrd_pkg::t_job w_q_job;

    itrd_front u_front (
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_pad_width (i_pad_width),
        .i_full      (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_job       (w_in_job)
    );

    itrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_q_job)
    );

    itrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .i_job        (w_q_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

### rtl/itrd_checker.sv
// Port-level checks for the radix digit converter, bound to the top level.
// Depends on itrd_pkg and integer_to_radix_digits_top.
`timescale 1ns / 1ps

module itrd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [63:0]                   i_value,
    input logic [itrd_pkg::RADIX_W-1:0]  i_radix,
    input logic [itrd_pkg::PAD_W-1:0]    i_pad_width,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [itrd_pkg::CHAR_W-1:0]   o_digit_char,
    input logic                          o_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit_char) && $stable(o_last))
        else $error("stalled result changed");

    // Only digit characters come out
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= 8'h30 && o_digit_char <= 8'h39) ||
                     (o_digit_char >= 8'h41 && o_digit_char <= 8'h5A)))
        else $error("result is not a digit character");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Reset empties the job queue
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind integer_to_radix_digits_top itrd_checker u_itrd_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for integer_to_radix_digits_top: directed table, then random numbers.
// Expected characters come from typed strings or an in-bench digit predictor. Depends on itrd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RAND_PER_PHASE = 19;
    localparam int DIR_ROWS       = 25;

    // Idle percentages per phase: none, sender, receiver, both
    localparam int SEND_PCT [4] = '{0, 50, 0, 29};
    localparam int RECV_PCT [4] = '{0, 0, 50, 29};

    typedef struct packed {
        logic [63:0]                   value;
        logic [itrd_pkg::RADIX_W-1:0]  radix;
        logic [itrd_pkg::PAD_W-1:0]    pad;
    } t_number_req;

    typedef struct packed {
        logic [itrd_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_char_beat;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [63:0]                   i_value;
    logic [itrd_pkg::RADIX_W-1:0]  i_radix;
    logic [itrd_pkg::PAD_W-1:0]    i_pad_width;
    logic                          o_valid;
    logic                          i_stall;
    logic [itrd_pkg::CHAR_W-1:0]   o_digit_char;
    logic                          o_last;

    t_char_beat  expected_chars [$];
    t_char_beat  head_beat;
    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Directed rows; a non-empty string is the expected output typed in directly
    t_number_req dir_rows [DIR_ROWS] = '{
        '{64'd0,                   6'd10, 7'd0},
        '{64'd0,                   6'd16, 7'd16},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd2,  7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd36, 7'd0},
        '{64'd35,                  6'd36, 7'd0},
        '{64'd10,                  6'd36, 7'd0},
        '{64'd9,                   6'd10, 7'd0},
        '{64'd255,                 6'd16, 7'd0},
        '{64'd5,                   6'd0,  7'd0},
        '{64'd5,                   6'd1,  7'd0},
        '{64'd36,                  6'd37, 7'd0},
        '{64'd36,                  6'd63, 7'd0},
        '{64'd7,                   6'd10, 7'd64},
        '{64'd7,                   6'd10, 7'd127},
        '{64'd7,                   6'd10, 7'd65},
        '{64'd123456789,           6'd10, 7'd0},
        '{64'd123456789,           6'd10, 7'd12},
        '{64'h8000_0000_0000_0000, 6'd2,  7'd0},
        '{64'h0123_4567_89AB_CDEF, 6'd16, 7'd16},
        '{64'hFEDC_BA98_7654_3210, 6'd16, 7'd0},
        '{64'd1295,                6'd36, 7'd0},
        '{64'h5555_5555_5555_5555, 6'd3,  7'd0},
        '{64'd100,                 6'd10, 7'd2},
        '{64'd1,                   6'd2,  7'd8}
    };

    string dir_text [DIR_ROWS] = '{
        "0", "0000000000000000", "FFFFFFFFFFFFFFFF", "", "", "Z", "A", "9", "FF",
        "101", "101", "10", "10", "", "", "", "123456789", "000123456789", "",
        "0123456789ABCDEF", "FEDCBA9876543210", "ZZ", "", "100", "00000001"
    };

    integer_to_radix_digits_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_pad_width  (i_pad_width),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Queue the characters of one number: clamp base and pad, divide, emit MSD first
    function automatic void predict_digits(input logic [63:0] value,
                                           input logic [itrd_pkg::RADIX_W-1:0] radix_in,
                                           input logic [itrd_pkg::PAD_W-1:0] pad_in);
        logic [63:0]                  quot;
        logic [63:0]                  base;
        logic [itrd_pkg::RADIX_W-1:0] digits [itrd_pkg::MAX_DIGITS];
        logic [itrd_pkg::RADIX_W-1:0] d;
        logic [itrd_pkg::CHAR_W-1:0]  ch;
        int unsigned                  ndig;
        int unsigned                  total;
        int unsigned                  from_end;

        base = 64'(radix_in);
        if (base < 64'(itrd_pkg::RADIX_MIN)) base = 64'(itrd_pkg::RADIX_MIN);
        if (base > 64'(itrd_pkg::RADIX_MAX)) base = 64'(itrd_pkg::RADIX_MAX);
        total = (pad_in > itrd_pkg::MAX_DIGITS) ? itrd_pkg::MAX_DIGITS : pad_in;

        // shift past the width gives zero, so a full-width mask comes out all ones
        quot = value & ((64'd1 << itrd_pkg::VALUE_BITS) - 64'd1);
        ndig = 0;
        do begin
            digits[ndig] = itrd_pkg::RADIX_W'(quot % base);
            quot         = quot / base;
            ndig++;
        end while (quot != 0 && ndig < itrd_pkg::MAX_DIGITS);

        if (ndig > total) total = ndig;
        for (int unsigned k = 0; k < total; k++) begin
            from_end = total - 1 - k;
            if (from_end < ndig) begin
                d  = digits[from_end];
                ch = (d < itrd_pkg::DEC_LIMIT)
                   ? itrd_pkg::CHAR_ZERO + itrd_pkg::CHAR_W'(d)
                   : itrd_pkg::CHAR_A + itrd_pkg::CHAR_W'(d - itrd_pkg::DEC_LIMIT);
            end else begin
                ch = itrd_pkg::CHAR_ZERO;
            end
            expected_chars.push_back('{ch: ch, last: (k + 1 == total)});
        end
    endfunction

    // One input transaction, with an optional idle gap in front
    task automatic send_number(input logic [63:0] value,
                               input logic [itrd_pkg::RADIX_W-1:0] radix,
                               input logic [itrd_pkg::PAD_W-1:0] pad,
                               input string typed);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_value     <= value;
        i_radix     <= radix;
        i_pad_width <= pad;
        do @(posedge i_clk); while (o_stall);

        if (typed.len() == 0) begin
            predict_digits(value, radix, pad);
        end else begin
            for (int k = 0; k < typed.len(); k++)
                expected_chars.push_back('{ch: typed[k], last: (k + 1 == typed.len())});
        end
    endtask

    // Hold off the sender until every queued character has come out
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Mostly in-range bases and values of random bit width; some out-of-range bases and pads
    task automatic send_random_number();
        logic [63:0]                  value;
        logic [itrd_pkg::RADIX_W-1:0] radix;
        logic [itrd_pkg::PAD_W-1:0]   pad;
        int unsigned                  bits;

        bits  = $urandom_range(64, 1);
        value = {$urandom, $urandom};
        if (bits < 64) value &= (64'd1 << bits) - 64'd1;
        if ($urandom_range(19) == 0) value = '0;
        if ($urandom_range(9) == 0)
            radix = itrd_pkg::RADIX_W'($urandom_range(63));
        else
            radix = itrd_pkg::RADIX_W'($urandom_range(36, 2));
        case ($urandom_range(3))
            0: pad = '0;
            1: pad = itrd_pkg::PAD_W'($urandom_range(16));
            2: pad = itrd_pkg::PAD_W'($urandom_range(64));
            default: pad = itrd_pkg::PAD_W'($urandom_range(127));
        endcase
        send_number(value, radix, pad, "");
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Output checker: each character transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character transaction: digit_char %h last %b",
                       o_digit_char, o_last);
                fail_count++;
            end else begin
                head_beat = expected_chars.pop_front();
                if (o_digit_char !== head_beat.ch) begin
                    $error("digit_char: expected %h, got %h", head_beat.ch, o_digit_char);
                    fail_count++;
                end
                if (o_last !== head_beat.last) begin
                    $error("last: expected %b, got %b", head_beat.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_value       = '0;
        i_radix       = '0;
        i_pad_width   = '0;
        i_stall       = 1'b0;
        fail_count    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_ROWS; n++)
            send_number(dir_rows[n].value, dir_rows[n].radix, dir_rows[n].pad, dir_text[n]);

        // Random numbers under each idling mix, draining between phases
        for (int ph = 0; ph < 4; ph++) begin
            wait_for_drain();
            send_idle_pct = SEND_PCT[ph];
            recv_idle_pct = RECV_PCT[ph];
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_random_number();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### integer_to_radix_digits_top.f
rtl/itrd_pkg.sv
rtl/itrd_ram.sv
rtl/itrd_front.sv
rtl/itrd_queue.sv
rtl/itrd_back.sv
rtl/integer_to_radix_digits_top.sv
rtl/itrd_checker.sv
verif/tb_top.sv
